[rtl/sqlts_pkg.sv]
// ----------------------------------------------------------------------------
// SQL token scanner package
// Scan modes, token kinds, record types, error codes, byte classes and the
// keyword table shared by the scanner modules.
// ----------------------------------------------------------------------------
package sqlts_pkg;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_LT    = 4'd1,
        M_GT    = 4'd2,
        M_MINUS = 4'd3,
        M_CR    = 4'd4,
        M_INT   = 4'd5,
        M_FRAC  = 4'd6,
        M_WORD  = 4'd7,
        M_STR   = 4'd8,
        M_ESC   = 4'd9
    } mode_t;

    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_BYTE_END = 2'd1;
    localparam logic [1:0] OP_END      = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] REC_TEXT  = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_OPEN_ESCAPE  = 3'd3;
    localparam logic [2:0] ERR_OPEN_STRING  = 3'd4;

    localparam logic [4:0] K_IDENT  = 5'd14;
    localparam logic [4:0] K_COMMA  = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_LPAREN = 5'd17;
    localparam logic [4:0] K_RPAREN = 5'd18;
    localparam logic [4:0] K_STAR   = 5'd19;
    localparam logic [4:0] K_EQ     = 5'd20;
    localparam logic [4:0] K_NE     = 5'd21;
    localparam logic [4:0] K_LT     = 5'd22;
    localparam logic [4:0] K_LE     = 5'd23;
    localparam logic [4:0] K_GT     = 5'd24;
    localparam logic [4:0] K_GE     = 5'd25;
    localparam logic [4:0] K_STRING = 5'd26;
    localparam logic [4:0] K_FLOAT  = 5'd27;
    localparam logic [4:0] K_INT    = 5'd28;
    localparam logic [4:0] K_END    = 5'd29;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MORE  = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam int KW_COUNT = 14;

    // Keyword text, right aligned: first character in the highest used byte.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        "SELECT", "FROM", "WHERE", "CREATE", "TABLE", "INSERT", "INTO",
        "VALUES", "INT", "FLOAT", "STRING", "AND", "OR", "NOT"};
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd4, 3'd6, 3'd3, 3'd5, 3'd6,
        3'd3, 3'd2, 3'd3};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic word_rest(input logic [7:0] c);
        return word_start(c) || is_digit(c);
    endfunction

    function automatic logic [7:0] upcase_byte(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

endpackage

[rtl/sqlts_step.sv]
// ----------------------------------------------------------------------------
// SQL token scanner step
// Combinational scan of one input beat: next scanner state and up to four
// packed result records.
// ----------------------------------------------------------------------------
module sqlts_step #(
    parameter int PW   = 16,
    parameter int KMAX = 6
) (
    input  logic [1:0]                          op,
    input  logic [7:0]                          byte_in,
    input  sqlts_pkg::mode_t                    mode_in,
    input  logic [PW-1:0]                       cur_line_in,
    input  logic [PW-1:0]                       cur_col_in,
    input  logic [PW-1:0]                       tok_line_in,
    input  logic [PW-1:0]                       tok_col_in,
    input  logic [KMAX-1:0][7:0]                kbuf_in,
    input  logic [$clog2(KMAX+1)-1:0]           klen_in,
    input  logic                                kovf_in,
    input  logic                                halted_in,
    output sqlts_pkg::mode_t                    mode_out,
    output logic [PW-1:0]                       cur_line_out,
    output logic [PW-1:0]                       cur_col_out,
    output logic [PW-1:0]                       tok_line_out,
    output logic [PW-1:0]                       tok_col_out,
    output logic [KMAX-1:0][7:0]                kbuf_out,
    output logic [$clog2(KMAX+1)-1:0]           klen_out,
    output logic                                kovf_out,
    output logic                                halted_out,
    output logic [2*PW+18:0]                    res [4],
    output logic [2:0]                          res_cnt
);
    import sqlts_pkg::*;

    localparam int LW  = $clog2(KMAX + 1);
    localparam int KIW = $clog2(KMAX);
    localparam int EW  = 2 * PW + 19;
    localparam logic [PW-1:0] PMAX = {PW{1'b1}};
    localparam logic [PW-1:0] PONE = {{(PW-1){1'b0}}, 1'b1};

    function automatic logic [EW-1:0] mk(input logic [1:0] t, input logic [4:0] k,
                                         input logic [PW-1:0] l, input logic [PW-1:0] col,
                                         input logic [7:0] b, input logic [2:0] e);
        return {t, k, l, col, b, e, 1'b0};
    endfunction

    function automatic logic [4:0] word_kind(input logic [KMAX-1:0][7:0] b,
                                             input logic [LW-1:0] l, input logic o);
        logic [4:0] kind;
        logic       hit;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (LW'(KW_LEN[k]) == l);
            for (int i = 0; i < 6; i++)
            begin
                if ((i < int'(l)) && (b[i] != KW_TEXT[k][(int'(l) - 1 - i) * 8 +: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = 5'(k);
            end
        end
        return o ? K_IDENT : kind;
    endfunction

    mode_t             m;
    logic [PW-1:0]     cl, cc, tl, tc;
    logic [KMAX-1:0][7:0] kb;
    logic [LW-1:0]     kl;
    logic              ko, h, do_idle, fin_fail;
    logic [2:0]        n, last_idx;
    logic [7:0]        c, v;
    logic [4:0]        single;

    always_comb
    begin
        m = mode_in; cl = cur_line_in; cc = cur_col_in; tl = tok_line_in; tc = tok_col_in;
        kb = kbuf_in; kl = klen_in; ko = kovf_in; h = halted_in;
        n = 3'd0; do_idle = 1'b0; fin_fail = 1'b0; v = 8'd0; single = 5'd0;
        c = byte_in; last_idx = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            res[i] = '0;
        end
        if (!h && (op != OP_NONE))
        begin
            if ((op == OP_BYTE) || (op == OP_BYTE_END))
            begin
                unique case (m)
                    M_LT:
                    begin
                        if (c == CH_EQ)
                        begin
                            m = M_IDLE; res[n[1:0]] = mk(REC_TOKEN, K_LE, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                        end
                        else if (c == CH_MORE)
                        begin
                            m = M_IDLE; res[n[1:0]] = mk(REC_TOKEN, K_NE, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_TOKEN, K_LT, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; do_idle = 1'b1;
                        end
                    end
                    M_GT:
                    begin
                        if (c == CH_EQ)
                        begin
                            m = M_IDLE; res[n[1:0]] = mk(REC_TOKEN, K_GE, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_TOKEN, K_GT, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; do_idle = 1'b1;
                        end
                    end
                    M_MINUS:
                    begin
                        if (is_digit(c))
                        begin
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, CH_MINUS, ERR_NONE);
                            n = n + 3'd1;
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                            n = n + 3'd1;
                            if (cc != PMAX) cc = cc + PONE;
                            m = M_INT;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_ERROR, 5'd0, tl, tc, 8'd0, ERR_UNEXPECTED);
                            n = n + 3'd1; h = 1'b1; m = M_IDLE;
                        end
                    end
                    M_CR:
                    begin
                        m = M_IDLE;
                        do_idle = (c != CH_LF);
                    end
                    M_INT:
                    begin
                        if (is_digit(c) || (c == CH_DOT))
                        begin
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                            n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                            if (c == CH_DOT) m = M_FRAC;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_TOKEN, K_INT, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; do_idle = 1'b1;
                        end
                    end
                    M_FRAC:
                    begin
                        if (is_digit(c))
                        begin
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                            n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_TOKEN, K_FLOAT, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; do_idle = 1'b1;
                        end
                    end
                    M_WORD:
                    begin
                        if (word_rest(c))
                        begin
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                            n = n + 3'd1;
                            if (kl < LW'(KMAX))
                            begin
                                kb[kl[KIW-1:0]] = upcase_byte(c);
                                kl = kl + LW'(1);
                            end
                            else
                            begin
                                ko = 1'b1;
                            end
                            if (cc != PMAX) cc = cc + PONE;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_TOKEN, word_kind(kb, kl, ko), tl, tc, 8'd0,
                                             ERR_NONE);
                            n = n + 3'd1; do_idle = 1'b1;
                        end
                    end
                    M_STR:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            if (cc != PMAX) cc = cc + PONE;
                            res[n[1:0]] = mk(REC_TOKEN, K_STRING, tl, tc, 8'd0, ERR_NONE);
                            n = n + 3'd1; m = M_IDLE;
                        end
                        else if (c == CH_BSL)
                        begin
                            if (cc != PMAX) cc = cc + PONE;
                            m = M_ESC;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                            n = n + 3'd1;
                            if (c == CH_LF)
                            begin
                                if (cl != PMAX) cl = cl + PONE;
                                cc = PONE;
                            end
                            else if (cc != PMAX)
                            begin
                                cc = cc + PONE;
                            end
                        end
                    end
                    M_ESC:
                    begin
                        if ((c == CH_QUOTE) || (c == CH_BSL) || (c == CH_N) || (c == CH_T))
                        begin
                            v = (c == CH_N) ? CH_LF : ((c == CH_T) ? CH_TAB : c);
                            res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, v, ERR_NONE);
                            n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                            m = M_STR;
                        end
                        else
                        begin
                            res[n[1:0]] = mk(REC_ERROR, 5'd0, cl, cc, 8'd0, ERR_BAD_ESCAPE);
                            n = n + 3'd1; h = 1'b1; m = M_IDLE;
                        end
                    end
                    default:
                    begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_idle)
                begin
                    m = M_IDLE; tl = cl; tc = cc;
                    priority if ((c == CH_SPACE) || (c == CH_TAB))
                    begin
                        if (cc != PMAX) cc = cc + PONE;
                    end
                    else if ((c == CH_LF) || (c == CH_CR))
                    begin
                        if (cl != PMAX) cl = cl + PONE;
                        cc = PONE;
                        if (c == CH_CR) m = M_CR;
                    end
                    else if ((c == CH_LESS) || (c == CH_MORE) || (c == CH_MINUS) ||
                             (c == CH_QUOTE))
                    begin
                        if (cc != PMAX) cc = cc + PONE;
                        m = (c == CH_LESS) ? M_LT : (c == CH_MORE) ? M_GT :
                            (c == CH_MINUS) ? M_MINUS : M_STR;
                    end
                    else if ((c == CH_COMMA) || (c == CH_SEMI) || (c == CH_LPAR) ||
                             (c == CH_RPAR) || (c == CH_STAR) || (c == CH_EQ))
                    begin
                        single = (c == CH_COMMA) ? K_COMMA : (c == CH_SEMI) ? K_SEMI :
                                 (c == CH_LPAR) ? K_LPAREN : (c == CH_RPAR) ? K_RPAREN :
                                 (c == CH_STAR) ? K_STAR : K_EQ;
                        res[n[1:0]] = mk(REC_TOKEN, single, tl, tc, 8'd0, ERR_NONE);
                        n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                    end
                    else if (is_digit(c))
                    begin
                        res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                        n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                        m = M_INT;
                    end
                    else if (word_start(c))
                    begin
                        kb[0] = upcase_byte(c); kl = LW'(1); ko = 1'b0;
                        res[n[1:0]] = mk(REC_TEXT, 5'd0, tl, tc, c, ERR_NONE);
                        n = n + 3'd1; if (cc != PMAX) cc = cc + PONE;
                        m = M_WORD;
                    end
                    else
                    begin
                        res[n[1:0]] = mk(REC_ERROR, 5'd0, cl, cc, 8'd0, ERR_UNEXPECTED);
                        n = n + 3'd1; h = 1'b1; m = M_IDLE;
                    end
                end
            end

            // End of source: flush a pending token and end token, or an error
            if ((op != OP_BYTE) && !h)
            begin
                unique case (m)
                    M_LT:    begin res[n[1:0]] = mk(REC_TOKEN, K_LT, tl, tc, 8'd0, ERR_NONE);
                             n = n + 3'd1; end
                    M_GT:    begin res[n[1:0]] = mk(REC_TOKEN, K_GT, tl, tc, 8'd0, ERR_NONE);
                             n = n + 3'd1; end
                    M_INT:   begin res[n[1:0]] = mk(REC_TOKEN, K_INT, tl, tc, 8'd0, ERR_NONE);
                             n = n + 3'd1; end
                    M_FRAC:  begin res[n[1:0]] = mk(REC_TOKEN, K_FLOAT, tl, tc, 8'd0, ERR_NONE);
                             n = n + 3'd1; end
                    M_WORD:  begin res[n[1:0]] = mk(REC_TOKEN, word_kind(kb, kl, ko), tl, tc,
                                                    8'd0, ERR_NONE);
                             n = n + 3'd1; end
                    M_MINUS: begin res[n[1:0]] = mk(REC_ERROR, 5'd0, tl, tc, 8'd0,
                                                    ERR_UNEXPECTED);
                             n = n + 3'd1; fin_fail = 1'b1; end
                    M_STR:   begin res[n[1:0]] = mk(REC_ERROR, 5'd0, cl, cc, 8'd0,
                                                    ERR_OPEN_STRING);
                             n = n + 3'd1; fin_fail = 1'b1; end
                    M_ESC:   begin res[n[1:0]] = mk(REC_ERROR, 5'd0, cl, cc, 8'd0,
                                                    ERR_OPEN_ESCAPE);
                             n = n + 3'd1; fin_fail = 1'b1; end
                    default: begin end
                endcase
                if (fin_fail)
                begin
                    h = 1'b1;
                end
                else
                begin
                    res[n[1:0]] = mk(REC_TOKEN, K_END, cl, cc, 8'd0, ERR_NONE);
                    n = n + 3'd1;
                    cl = PONE; cc = PONE; tl = PONE; tc = PONE;
                end
                m = M_IDLE;
            end
        end

        if (n != 3'd0)
        begin
            last_idx = n - 3'd1;
            res[last_idx[1:0]][0] = 1'b1;
        end

        mode_out = m; cur_line_out = cl; cur_col_out = cc; tok_line_out = tl;
        tok_col_out = tc; kbuf_out = kb; klen_out = kl; kovf_out = ko; halted_out = h;
        res_cnt = n;
    end

endmodule

[rtl/sqlts_bank.sv]
// ----------------------------------------------------------------------------
// SQL token scanner result bank
// Holds the records of one scanned beat and hands them out one per cycle while take is high.
// ----------------------------------------------------------------------------
module sqlts_bank #(
    parameter int EW = 51
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [EW-1:0] load_res [4],
    input  logic [2:0]    load_cnt,
    input  logic          take,
    output logic          free,
    output logic          have,
    output logic [EW-1:0] head
);
    logic [EW-1:0] slot_reg [4];
    logic [2:0]    cnt_reg, cnt_next;
    logic [1:0]    ptr_reg, ptr_next;
    logic [2:0]    ptr_ext;
    logic          last_take;

    assign have      = (cnt_reg != 3'd0);
    assign ptr_ext   = {1'b0, ptr_reg};
    assign last_take = have && take && ((ptr_ext + 3'd1) == cnt_reg);
    assign free      = !have || last_take;
    assign head      = slot_reg[ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (load)
        begin
            cnt_next = load_cnt;
            ptr_next = 2'd0;
        end
        else if (last_take)
        begin
            cnt_next = 3'd0;
            ptr_next = 2'd0;
        end
        else if (have && take)
        begin
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            ptr_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                slot_reg[i] <= load_res[i];
            end
        end
    end

endmodule

[rtl/sql_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// SQL token scanner core
// Byte-at-a-time SQL tokenizer with line and column tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op and source_byte. op 0 is a
//   byte, op 1 a byte followed by end of source, op 2 end of source alone.
//   Output channel (out_valid/out_ready) carries one record per beat: a text
//   byte, a finished token with its start position, or an error.
//   last_result marks the final record caused by one input beat.
// Flow: an accepted beat waits in the input register until the result bank
//   is free; its records then leave one per cycle while out_ready is high.
// Throughput: one input beat per cycle while out_ready is high and each
//   beat yields at most one record; a beat yielding more records holds the
//   next until the single output port has drained the result bank.
// Reset: the scanner returns to idle at line 1, column 1, not halted, with
//   both register stages empty.
// Stall: while out_ready is low the bank holds its records and the input
//   register keeps one more beat; in_ready then drops.
// After an error record the scanner is halted: inputs are taken and dropped
//   until reset.
// ----------------------------------------------------------------------------
module sql_token_scanner_core #(
    parameter int POSITION_WIDTH  = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  logic [7:0]                source_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                record_type,
    output logic [4:0]                token_kind,
    output logic [POSITION_WIDTH-1:0] token_line,
    output logic [POSITION_WIDTH-1:0] start_column,
    output logic [7:0]                text_byte,
    output logic [2:0]                error_code,
    output logic                      last_result
);
    import sqlts_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);
    localparam int EW = 2 * PW + 19;
    localparam logic [PW-1:0] PONE = {{(PW-1){1'b0}}, 1'b1};

    // Input register
    logic       in_vld_reg;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;

    // Scanner state
    mode_t                         mode_reg, mode_next;
    logic [PW-1:0]                 cur_line_reg, cur_line_next;
    logic [PW-1:0]                 cur_col_reg, cur_col_next;
    logic [PW-1:0]                 tok_line_reg, tok_line_next;
    logic [PW-1:0]                 tok_col_reg, tok_col_next;
    logic [KEYWORD_MAX_LEN-1:0][7:0] kbuf_reg, kbuf_next;
    logic [LW-1:0]                 klen_reg, klen_next;
    logic                          kovf_reg, kovf_next;
    logic                          halted_reg, halted_next;

    logic [EW-1:0] step_res [4];
    logic [2:0]    step_cnt;
    logic          bank_free, bank_have, load;
    logic [EW-1:0] head;

    sqlts_step #(.PW(PW), .KMAX(KEYWORD_MAX_LEN)) u_step (
        .op           (op_reg),
        .byte_in      (byte_reg),
        .mode_in      (mode_reg),
        .cur_line_in  (cur_line_reg),
        .cur_col_in   (cur_col_reg),
        .tok_line_in  (tok_line_reg),
        .tok_col_in   (tok_col_reg),
        .kbuf_in      (kbuf_reg),
        .klen_in      (klen_reg),
        .kovf_in      (kovf_reg),
        .halted_in    (halted_reg),
        .mode_out     (mode_next),
        .cur_line_out (cur_line_next),
        .cur_col_out  (cur_col_next),
        .tok_line_out (tok_line_next),
        .tok_col_out  (tok_col_next),
        .kbuf_out     (kbuf_next),
        .klen_out     (klen_next),
        .kovf_out     (kovf_next),
        .halted_out   (halted_next),
        .res          (step_res),
        .res_cnt      (step_cnt)
    );

    sqlts_bank #(.EW(EW)) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .load_res (step_res),
        .load_cnt (step_cnt),
        .take     (out_ready),
        .free     (bank_free),
        .have     (bank_have),
        .head     (head)
    );

    // Scan the held beat once the bank can take its records
    assign load     = in_vld_reg && bank_free;
    assign in_ready = !in_vld_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            mode_reg     <= M_IDLE;
            cur_line_reg <= PONE;
            cur_col_reg  <= PONE;
            tok_line_reg <= PONE;
            tok_col_reg  <= PONE;
            klen_reg     <= '0;
            kovf_reg     <= 1'b0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (load)
            begin
                in_vld_reg <= 1'b0;
            end
            if (load)
            begin
                mode_reg     <= mode_next;
                cur_line_reg <= cur_line_next;
                cur_col_reg  <= cur_col_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
                klen_reg     <= klen_next;
                kovf_reg     <= kovf_next;
                halted_reg   <= halted_next;
            end
        end
    end

    // Payload registers: hold the beat and the keyword bytes
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            byte_reg <= source_byte;
        end
        if (load)
        begin
            kbuf_reg <= kbuf_next;
        end
    end

    assign out_valid    = bank_have;
    assign record_type  = head[EW-1 -: 2];
    assign token_kind   = head[EW-3 -: 5];
    assign token_line   = head[EW-8 -: PW];
    assign start_column = head[EW-8-PW -: PW];
    assign text_byte    = head[11:4];
    assign error_code   = head[3:1];
    assign last_result  = head[0];

`ifndef SYNTH
    // Once halted, the scanner stays halted until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    // An error record always closes the records of its beat
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (record_type == REC_ERROR)) |-> last_result)
        else $error("error record not marked last");

    // A halted scanner emits nothing for later beats
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (load && halted_reg) |-> (step_cnt == 3'd0))
        else $error("records produced while halted");

    // An end token leaves the position at line 1, column 1
    a_end_home: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !halted_next && ((op_reg == OP_BYTE_END) || (op_reg == OP_END)))
        |=> ((cur_line_reg == PONE) && (cur_col_reg == PONE) && (mode_reg == M_IDLE)))
        else $error("position not reset after end of source");
`endif

endmodule
